// ===== hdl/spc_pkg.sv =====
`default_nettype none

package spc_pkg;

  localparam int NUM_BANDS = 256;
  localparam int BAND_W    = $clog2(NUM_BANDS);

  localparam int MAG_W   = 24;
  localparam int IDX_W   = 8;
  localparam int DECAY_W = 16;
  localparam int WSUM_W  = 40;
  localparam int TSUM_W  = 32;
  localparam int WPROD_W = MAG_W + BAND_W + 1;
  localparam int CENT_W  = 16;
  localparam int FRAC_W  = 8;
  localparam int ALPHA_W = 8;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [DECAY_W-1:0] DECAY_RESET     = 16'd63570;
  localparam logic [TSUM_W-1:0]  THRESHOLD_RESET = 32'd256000;
  localparam logic [ALPHA_W-1:0] FADE_STEP_RESET = 8'd5;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 8'd255;
  localparam logic [TSUM_W-1:0]  SILENT_VOLUME   = 32'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_FACTOR      = 2'd0,
    CFG_SILENCE_THRESHOLD = 2'd1,
    CFG_FADE_STEP         = 2'd2,
    CFG_ALPHA_FULL        = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [WSUM_W-1:0] wsum;
    logic [TSUM_W-1:0] tsum;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [CENT_W-1:0] quotient;
  } div_sts_t;

endpackage

`default_nettype wire

// ===== hdl/spc_peak_ram.sv =====
`default_nettype none

module spc_peak_ram (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [spc_pkg::BAND_W-1:0]     rd_addr,
  output logic      [spc_pkg::MAG_W-1:0]      rd_data,
  input  wire logic                           wr_en,
  input  wire logic [spc_pkg::BAND_W-1:0]     wr_addr,
  input  wire logic [spc_pkg::MAG_W-1:0]      wr_data
);

  logic [spc_pkg::MAG_W-1:0]     mem [spc_pkg::NUM_BANDS];
  logic [spc_pkg::NUM_BANDS-1:0] vld;
  logic [spc_pkg::MAG_W-1:0]     rd_q;
  logic                          rd_vld;

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

// ===== hdl/spc_divider.sv =====
`default_nettype none

module spc_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spc_pkg::div_req_t req,
  input  wire logic              take,
  output spc_pkg::div_sts_t      sts
);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  localparam int CNT_W = $clog2(spc_pkg::CENT_W);

  div_state_t                    state;
  logic [spc_pkg::TSUM_W-1:0]    divisor;
  logic [spc_pkg::TSUM_W-1:0]    rem;
  logic [spc_pkg::CENT_W-1:0]    low_bits;
  logic [spc_pkg::CENT_W-1:0]    quotient;
  logic [CNT_W-1:0]              cnt;
  logic [spc_pkg::TSUM_W:0]      trial;
  logic [spc_pkg::TSUM_W:0]      trial_diff;
  logic                          too_big;

  assign trial      = {rem, low_bits[spc_pkg::CENT_W-1]};
  assign trial_diff = trial - {1'b0, divisor};
  assign too_big    = req.wsum >= {req.tsum, spc_pkg::FRAC_W'(0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      case (state)
        DIV_IDLE: begin
          if (req.start) begin
            divisor <= req.tsum;
            cnt     <= '0;
            if (req.wsum == '0) begin
              quotient <= '0;
              state    <= DIV_DONE;
            end else if (too_big) begin
              quotient <= '1;
              state    <= DIV_DONE;
            end else begin
              rem      <= req.wsum[spc_pkg::WSUM_W-1:spc_pkg::FRAC_W];
              low_bits <= {req.wsum[spc_pkg::FRAC_W-1:0],
                           (spc_pkg::CENT_W - spc_pkg::FRAC_W)'(0)};
              state    <= DIV_RUN;
            end
          end
        end
        DIV_RUN: begin
          if (!trial_diff[spc_pkg::TSUM_W]) begin
            rem      <= trial_diff[spc_pkg::TSUM_W-1:0];
            quotient <= {quotient[spc_pkg::CENT_W-2:0], 1'b1};
          end else begin
            rem      <= trial[spc_pkg::TSUM_W-1:0];
            quotient <= {quotient[spc_pkg::CENT_W-2:0], 1'b0};
          end
          low_bits <= {low_bits[spc_pkg::CENT_W-2:0], 1'b0};
          cnt      <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(spc_pkg::CENT_W - 1)) begin
            state <= DIV_DONE;
          end
        end
        DIV_DONE: begin
          if (take) begin
            state <= DIV_IDLE;
          end
        end
        default: begin
          state <= DIV_IDLE;
        end
      endcase
    end
  end

  assign sts.busy     = (state == DIV_RUN);
  assign sts.done     = (state == DIV_DONE);
  assign sts.quotient = quotient;

endmodule

`default_nettype wire

// ===== hdl/spectrum_peak_hold_centroid.sv =====
// Bands are taken at one per cycle while no frame result is pending; the peak store
// is updated by read, decay, compare and write-back in a four stage pipeline with
// forwarding between bands. A frame's result bypasses the 16 step centroid divider
// on silence or on a quotient overflow, which saturates, and goes through it otherwise.
// From the last band until its result enters the output register no band is taken.
// Synchronous reset clears all peaks and both sums and loads the configuration reset values.
`default_nettype none

module spectrum_peak_hold_centroid (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // magnitude[23:0], band_index[31:24]
  input  wire logic [spc_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // centroid[15:0], volume[47:16], fade_alpha[55:48]
  output logic      [spc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // silent[0]
  output logic                                   m_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [spc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [spc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [spc_pkg::DECAY_W-1:0] decay_factor;
  logic [spc_pkg::TSUM_W-1:0]  silence_threshold;
  logic [spc_pkg::ALPHA_W-1:0] fade_step;
  logic [spc_pkg::ALPHA_W-1:0] alpha_full;

  logic                        frame_pending;
  logic                        in_xfer;

  logic                        s1_valid;
  logic                        s1_last;
  logic [spc_pkg::BAND_W-1:0]  s1_idx;
  logic [spc_pkg::MAG_W-1:0]   s1_mag;
  logic [spc_pkg::MAG_W-1:0]   s1_old;

  logic                        s2_valid;
  logic                        s2_last;
  logic [spc_pkg::BAND_W-1:0]  s2_idx;
  logic [spc_pkg::MAG_W-1:0]   s2_mag;
  logic [spc_pkg::MAG_W+spc_pkg::DECAY_W-1:0] s2_prod;
  logic [spc_pkg::MAG_W-1:0]   s2_decayed;
  logic [spc_pkg::MAG_W-1:0]   s2_peak;

  logic                        s3_valid;
  logic                        s3_last;
  logic [spc_pkg::BAND_W-1:0]  s3_idx;
  logic [spc_pkg::MAG_W-1:0]   s3_peak;
  logic [spc_pkg::BAND_W:0]    s3_weight;

  logic                        s4_valid;
  logic                        s4_last;
  logic [spc_pkg::MAG_W-1:0]   s4_peak;
  logic [spc_pkg::WPROD_W-1:0] s4_wprod;

  logic [spc_pkg::WSUM_W-1:0]  wsum;
  logic [spc_pkg::TSUM_W-1:0]  tsum;
  logic [spc_pkg::WSUM_W:0]    wsum_add;
  logic [spc_pkg::TSUM_W:0]    tsum_add;
  logic [spc_pkg::WSUM_W-1:0]  wsum_next;
  logic [spc_pkg::TSUM_W-1:0]  tsum_next;
  logic [spc_pkg::TSUM_W-1:0]  volume_next;
  logic [spc_pkg::ALPHA_W-1:0] alpha_faded;
  logic [spc_pkg::ALPHA_W-1:0] alpha_next;

  logic [spc_pkg::ALPHA_W-1:0] alpha_level;
  logic [spc_pkg::TSUM_W-1:0]  res_volume;
  logic                        res_silent;

  logic [spc_pkg::MAG_W-1:0]   rd_data;
  spc_pkg::div_req_t           div_req;
  spc_pkg::div_sts_t           div_sts;
  logic                        out_load;

  assign cfg_ready = 1'b1;
  assign s_tready  = !frame_pending;
  assign in_xfer   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor      <= spc_pkg::DECAY_RESET;
      silence_threshold <= spc_pkg::THRESHOLD_RESET;
      fade_step         <= spc_pkg::FADE_STEP_RESET;
      alpha_full        <= spc_pkg::ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (spc_pkg::cfg_reg_t'(cfg_index))
        spc_pkg::CFG_DECAY_FACTOR:      decay_factor      <= cfg_data[spc_pkg::DECAY_W-1:0];
        spc_pkg::CFG_SILENCE_THRESHOLD: silence_threshold <= cfg_data[spc_pkg::TSUM_W-1:0];
        spc_pkg::CFG_FADE_STEP:         fade_step         <= cfg_data[spc_pkg::ALPHA_W-1:0];
        spc_pkg::CFG_ALPHA_FULL:        alpha_full        <= cfg_data[spc_pkg::ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  spc_peak_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (s_tdata[spc_pkg::MAG_W +: spc_pkg::BAND_W]),
    .rd_data (rd_data),
    .wr_en   (s2_valid),
    .wr_addr (s2_idx),
    .wr_data (s2_peak)
  );

  // The two bands ahead may still be writing the same entry.
  always_comb begin
    if (s2_valid && (s2_idx == s1_idx)) begin
      s1_old = s2_peak;
    end else if (s3_valid && (s3_idx == s1_idx)) begin
      s1_old = s3_peak;
    end else begin
      s1_old = rd_data;
    end
  end

  assign s2_decayed = s2_prod[spc_pkg::DECAY_W +: spc_pkg::MAG_W];
  assign s2_peak    = (s2_decayed > s2_mag) ? s2_decayed : s2_mag;
  assign s3_weight  = {1'b0, s3_idx} + (spc_pkg::BAND_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= in_xfer;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_last  <= s_tlast;
    s1_idx   <= s_tdata[spc_pkg::MAG_W +: spc_pkg::BAND_W];
    s1_mag   <= s_tdata[spc_pkg::MAG_W-1:0];
    s2_last  <= s1_last;
    s2_idx   <= s1_idx;
    s2_mag   <= s1_mag;
    s2_prod  <= (spc_pkg::MAG_W + spc_pkg::DECAY_W)'(s1_old) *
                (spc_pkg::MAG_W + spc_pkg::DECAY_W)'(decay_factor);
    s3_last  <= s2_last;
    s3_idx   <= s2_idx;
    s3_peak  <= s2_peak;
    s4_last  <= s3_last;
    s4_peak  <= s3_peak;
    s4_wprod <= spc_pkg::WPROD_W'(s3_peak) * spc_pkg::WPROD_W'(s3_weight);
  end

  assign wsum_add    = {1'b0, wsum} + (spc_pkg::WSUM_W + 1)'(s4_wprod);
  assign tsum_add    = {1'b0, tsum} + (spc_pkg::TSUM_W + 1)'(s4_peak);
  assign wsum_next   = wsum_add[spc_pkg::WSUM_W] ? '1 : wsum_add[spc_pkg::WSUM_W-1:0];
  assign tsum_next   = tsum_add[spc_pkg::TSUM_W] ? '1 : tsum_add[spc_pkg::TSUM_W-1:0];
  assign volume_next = (wsum_next == '0) ? spc_pkg::SILENT_VOLUME : tsum_next;
  assign alpha_faded = (alpha_level > fade_step) ? (alpha_level - fade_step) : '0;
  assign alpha_next  = (volume_next < silence_threshold) ? alpha_faded : alpha_full;

  assign div_req.start = s4_valid && s4_last;
  assign div_req.wsum  = wsum_next;
  assign div_req.tsum  = tsum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      wsum        <= '0;
      tsum        <= '0;
      alpha_level <= spc_pkg::ALPHA_RESET;
    end else if (s4_valid) begin
      if (s4_last) begin
        wsum        <= '0;
        tsum        <= '0;
        alpha_level <= alpha_next;
      end else begin
        wsum <= wsum_next;
        tsum <= tsum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_valid && s4_last) begin
      res_volume <= volume_next;
      res_silent <= (wsum_next == '0);
    end
  end

  spc_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .take (out_load),
    .sts  (div_sts)
  );

  assign out_load = div_sts.done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      frame_pending <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (out_load) begin
        frame_pending <= 1'b0;
      end else if (in_xfer && s_tlast) begin
        frame_pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {alpha_level, res_volume, div_sts.quotient};
      m_tuser <= res_silent;
    end
  end

  a_one_frame_in_flight: assert property (@(posedge clk) disable iff (rst)
    $countones({s1_valid && s1_last, s2_valid && s2_last,
                s3_valid && s3_last, s4_valid && s4_last}) <= 1)
    else $error("more than one frame end in the pipeline");

  a_ready_means_div_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!div_sts.busy && !div_sts.done))
    else $error("input ready while a frame result is outstanding");

  a_frame_end_starts_div: assert property (@(posedge clk) disable iff (rst)
    (s4_valid && s4_last) |=> (div_sts.busy || div_sts.done))
    else $error("frame end did not start the divider");

  a_silent_format: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[15:0] == 16'd0 && m_tdata[47:16] == spc_pkg::SILENT_VOLUME))
    else $error("silent result with nonzero centroid or wrong volume");

endmodule

`default_nettype wire

// ===== tb/centroid_checker.sv =====
module centroid_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  input  wire logic                            s_tready,
  input  wire logic [spc_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                            s_tlast,
  input  wire logic                            m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic [spc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                            m_tuser,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [spc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [spc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                   mismatches,
  output int                                   frames_pending,
  output int                                   frames_checked
);
  import spc_pkg::*;

  localparam logic [63:0] WSUM_LIMIT = (64'd1 << WSUM_W) - 1;
  localparam logic [63:0] TSUM_LIMIT = (64'd1 << TSUM_W) - 1;

  typedef struct {
    logic [CENT_W-1:0]  centroid;
    logic [TSUM_W-1:0]  volume;
    logic [ALPHA_W-1:0] alpha;
    logic               silent;
  } frame_result_t;

  logic [MAG_W-1:0]   peak_hold [NUM_BANDS];
  logic [WSUM_W-1:0]  band_weighted_sum;
  logic [TSUM_W-1:0]  band_total_sum;
  logic [ALPHA_W-1:0] alpha_now;

  logic [DECAY_W-1:0] decay_q16;
  logic [TSUM_W-1:0]  quiet_level;
  logic [ALPHA_W-1:0] alpha_step;
  logic [ALPHA_W-1:0] alpha_restore;

  frame_result_t expected_frames [$];

  // Decays the stored peak of one band, folds the new magnitude in and, on the
  // last band of a frame, queues the frame's centroid, volume, alpha and silent flag.
  task automatic fold_band(input logic [MAG_W-1:0] mag, input logic [IDX_W-1:0] idx,
                           input logic last);
    logic [63:0]       decayed;
    logic [63:0]       peak;
    logic [63:0]       acc;
    logic [63:0]       quotient;
    logic [BAND_W-1:0] band;
    frame_result_t     res;
    band = BAND_W'(32'(idx) % NUM_BANDS);
    decayed = (64'(peak_hold[band]) * 64'(decay_q16)) >> 16;
    peak = (decayed > 64'(mag)) ? decayed : 64'(mag);
    peak_hold[band] = peak[MAG_W-1:0];
    acc = 64'(band_weighted_sum) + peak * (64'(band) + 64'd1);
    band_weighted_sum = (acc > WSUM_LIMIT) ? WSUM_LIMIT[WSUM_W-1:0] : acc[WSUM_W-1:0];
    acc = 64'(band_total_sum) + peak;
    band_total_sum = (acc > TSUM_LIMIT) ? TSUM_LIMIT[TSUM_W-1:0] : acc[TSUM_W-1:0];
    if (last) begin
      res.silent = (band_weighted_sum == '0);
      if (res.silent || band_total_sum == '0) begin
        res.centroid = '0;
        res.volume = SILENT_VOLUME;
      end else begin
        quotient = (64'(band_weighted_sum) << FRAC_W) / 64'(band_total_sum);
        res.centroid = (quotient > 64'hFFFF) ? '1 : quotient[CENT_W-1:0];
        res.volume = band_total_sum;
      end
      if (res.volume < quiet_level) begin
        alpha_now = (alpha_now > alpha_step) ? alpha_now - alpha_step : '0;
      end else begin
        alpha_now = alpha_restore;
      end
      res.alpha = alpha_now;
      expected_frames.push_back(res);
      band_weighted_sum = '0;
      band_total_sum = '0;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      foreach (peak_hold[i]) peak_hold[i] = '0;
      band_weighted_sum = '0;
      band_total_sum = '0;
      alpha_now = ALPHA_RESET;
      decay_q16 = DECAY_RESET;
      quiet_level = THRESHOLD_RESET;
      alpha_step = FADE_STEP_RESET;
      alpha_restore = ALPHA_RESET;
      expected_frames.delete();
      mismatches = 0;
      frames_checked = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_frames.size() == 0) begin
          mismatches++;
          $error("result transfer with no frame expected");
        end else begin
          want = expected_frames.pop_front();
          frames_checked++;
          if (m_tdata[15:0] !== want.centroid) begin
            mismatches++;
            $error("centroid: expected %0d, got %0d", want.centroid, m_tdata[15:0]);
          end
          if (m_tdata[47:16] !== want.volume) begin
            mismatches++;
            $error("volume: expected %0d, got %0d", want.volume, m_tdata[47:16]);
          end
          if (m_tdata[55:48] !== want.alpha) begin
            mismatches++;
            $error("fade_alpha: expected %0d, got %0d", want.alpha, m_tdata[55:48]);
          end
          if (m_tuser !== want.silent) begin
            mismatches++;
            $error("silent: expected %0d, got %0d", want.silent, m_tuser);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DECAY_FACTOR:      decay_q16 = cfg_data[DECAY_W-1:0];
          CFG_SILENCE_THRESHOLD: quiet_level = cfg_data[TSUM_W-1:0];
          CFG_FADE_STEP:         alpha_step = cfg_data[ALPHA_W-1:0];
          CFG_ALPHA_FULL:        alpha_restore = cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        fold_band(s_tdata[MAG_W-1:0], s_tdata[MAG_W+IDX_W-1:MAG_W], s_tlast);
      end
    end
    frames_pending = expected_frames.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import spc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 40;
  localparam int HOLD_TICKS   = 400;
  localparam int PHASE_BANDS  = 30;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_reg_t               cfg_index = CFG_DECAY_FACTOR;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int mismatches;
  int frames_pending;
  int frames_checked;
  int bands_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int holds_asked    = 0;
  int holds_done     = 0;
  int hold_left      = 0;
  int cycles         = 0;

  spectrum_peak_hold_centroid u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  centroid_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .frames_pending (frames_pending),
    .frames_checked (frames_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // The result side; a requested hold-off keeps tready low long enough for the
  // output register and the band input to back up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else if (holds_done < holds_asked) begin
      holds_done++;
      hold_left = HOLD_TICKS - 1;
      m_tready = 1'b0;
    end else begin
      m_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_band(input logic [MAG_W-1:0] mag, input logic [IDX_W-1:0] idx,
                           input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {idx, mag};
    s_tlast = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bands_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input logic [DECAY_W-1:0] decay, input logic [TSUM_W-1:0] thr,
                           input logic [ALPHA_W-1:0] step, input logic [ALPHA_W-1:0] full);
    write_reg(CFG_DECAY_FACTOR, CFG_DATA_W'(decay));
    write_reg(CFG_SILENCE_THRESHOLD, thr);
    write_reg(CFG_FADE_STEP, CFG_DATA_W'(step));
    write_reg(CFG_ALPHA_FULL, CFG_DATA_W'(full));
  endtask

  task automatic settle;
    @(negedge clk);
    s_tvalid = 1'b0;
    while (frames_pending != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  function automatic logic [MAG_W-1:0] pick_magnitude(input bit quiet);
    int roll;
    roll = $urandom_range(99);
    if (quiet) return MAG_W'($urandom_range(255));
    if (roll < 15) return '0;
    if (roll < 30) return MAG_W'($urandom_range(255));
    if (roll < 40) return '1;
    return MAG_W'($urandom);
  endfunction

  task automatic send_frame(input bit quiet);
    int roll;
    int bands;
    int first;
    bit scattered;
    logic [IDX_W-1:0] idx;
    roll = $urandom_range(99);
    if (roll < 80) bands = $urandom_range(8, 1);
    else if (roll < 95) bands = $urandom_range(32, 9);
    else bands = $urandom_range(64, 33);
    first = $urandom_range(255);
    scattered = $urandom_range(1);
    for (int k = 0; k < bands; k++) begin
      idx = scattered ? IDX_W'($urandom_range(255)) : IDX_W'(first + k);
      send_band(pick_magnitude(quiet), idx, k == bands - 1);
    end
  endtask

  task automatic run_frames(input int count);
    int goal;
    goal = bands_sent + count;
    while (bands_sent < goal) send_frame($urandom_range(99) < 30);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frames under the reset configuration.
    send_band('0, 8'd0, 1'b1);
    send_band('0, 8'd255, 1'b1);
    send_band('1, 8'd255, 1'b1);
    send_band('1, 8'd0, 1'b0);
    send_band('1, 8'd255, 1'b1);
    send_band(24'h012345, 8'd7, 1'b1);
    send_band('0, 8'd7, 1'b1);
    send_band('0, 8'd7, 1'b1);
    send_band('0, 8'd7, 1'b1);
    send_band(24'h000100, 8'd10, 1'b0);
    send_band(24'h003000, 8'd11, 1'b0);
    send_band(24'h000080, 8'd12, 1'b0);
    send_band(24'h7FFFFF, 8'd13, 1'b1);
    send_band(24'h000001, 8'd128, 1'b1);
    send_band(24'hAAAAAA, 8'h55, 1'b0);
    send_band(24'h555555, 8'hAA, 1'b1);
    send_band('0, 8'd200, 1'b0);
    send_band('0, 8'd201, 1'b1);
    settle();

    write_all('0, '0, 8'd255, 8'd0);
    send_idle_pct = 66;
    recv_stall_pct = 0;
    run_frames(PHASE_BANDS);
    settle();

    write_all('1, '1, 8'd0, 8'd255);
    send_idle_pct = 0;
    recv_stall_pct = 66;
    @(negedge clk);
    holds_asked++;
    run_frames(PHASE_BANDS);
    // One very loud frame drives both sums into saturation.
    for (int k = 0; k <= NUM_BANDS; k++) send_band('1, 8'd255, k == NUM_BANDS);
    settle();

    write_all(DECAY_W'($urandom), TSUM_W'($urandom_range(2000000)),
              ALPHA_W'($urandom), ALPHA_W'($urandom));
    send_idle_pct = 7;
    recv_stall_pct = 7;
    run_frames(PHASE_BANDS);
    settle();

    write_all(DECAY_RESET, THRESHOLD_RESET, FADE_STEP_RESET, ALPHA_RESET);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_frames(PHASE_BANDS);
    settle();

    $display("tb: %0d bands sent, %0d frame results checked over five phases",
             bands_sent, frames_checked);
    $display("tb: covered silence, centroid and sum saturation, extreme decay and threshold");
    if (mismatches == 0 && frames_pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
